// ===== rtl/cqr_pkg.sv =====
// ============================================================================
// cqr_pkg: shared types and constants for the quarter-round execute unit
// Opcode codes, word widths and the fixed rotation amounts of the round.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cqr_pkg;

	localparam int unsigned XLEN = 64;
	localparam int unsigned WLEN = 32;

	// Operation codes carried on cmd
	typedef enum logic [2:0] {
		CMD_PACK   = 3'd0,
		CMD_PACKH  = 3'd1,
		CMD_PACKHL = 3'd2,
		CMD_QR_AD  = 3'd3,
		CMD_QR_BC  = 3'd4
	} cmd_t;

	typedef logic [XLEN-1:0] xword_t;
	typedef logic [WLEN-1:0] word_t;

	// Fixed rotation amounts of the quarter round
	localparam int unsigned ROT_16 = 16;
	localparam int unsigned ROT_12 = 12;
	localparam int unsigned ROT_8  = 8;
	localparam int unsigned ROT_24 = 24;
	localparam int unsigned ROT_7  = 7;

	// Rotate a word left by a constant amount between 1 and WLEN-1
	function automatic word_t rol32(input word_t x, input int unsigned n);
		rol32 = (x << n) | (x >> (WLEN - n));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha_quarter_round_alu.sv =====
// ============================================================================
// chacha_quarter_round_alu: pack and quarter-round execute unit
// Registers one command per cycle, computes it, and strobes the result.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+------------------------------
//   command  | cmd, src_one, src_two         | start high, busy low at edge
//   result   | dest_value                    | done high for one cycle
//
// From acceptance to the done strobe each transaction passes the input
// register, then the result register behind the datapath.
// A new transaction is taken every cycle; busy is held low.
// The path is set by three chained 32-bit adds of the a/d half round.
// Reset clears the valid flags only; the receiver cannot stall.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module chacha_quarter_round_alu (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire [2:0]            cmd,
	input  wire cqr_pkg::xword_t src_one,
	input  wire cqr_pkg::xword_t src_two,
	output logic                 done,
	output cqr_pkg::xword_t      dest_value
);

	logic            valid_s1;
	logic [2:0]      cmd_s1;
	cqr_pkg::xword_t src_one_s1, src_two_s1;
	cqr_pkg::xword_t ad_value, bc_value, sel_value;
	logic            valid_s2;
	cqr_pkg::xword_t dest_s2;
	logic            accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Track valid transactions through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the command operands
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			src_one_s1 <= src_one;
			src_two_s1 <= src_two;
		end
	end

	cqr_qround u_qround (
		.src_one  (src_one_s1),
		.src_two  (src_two_s1),
		.ad_value (ad_value),
		.bc_value (bc_value)
	);

	cqr_result_sel u_result_sel (
		.cmd        (cmd_s1),
		.src_one    (src_one_s1),
		.src_two    (src_two_s1),
		.ad_value   (ad_value),
		.bc_value   (bc_value),
		.dest_value (sel_value)
	);

	// Hold the selected result for its strobe cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dest_s2 <= sel_value;
		end
	end

	assign done       = valid_s2;
	assign dest_value = dest_s2;

endmodule

`default_nettype wire

// ===== rtl/cqr_qround.sv =====
// ============================================================================
// cqr_qround: quarter-round datapath
// Computes the new a/d pair and the new b/c pair from the registered sources.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cqr_qround (
	input  wire cqr_pkg::xword_t src_one,
	input  wire cqr_pkg::xword_t src_two,
	output cqr_pkg::xword_t      ad_value,
	output cqr_pkg::xword_t      bc_value
);

	cqr_pkg::word_t hi_one, lo_one, hi_two, lo_two;
	cqr_pkg::word_t ad_a1, ad_d1, ad_c1, ad_b1, ad_a2, ad_d2;
	cqr_pkg::word_t bc_d1, bc_c1, bc_b1, bc_c2, bc_b2;

	// Split the sources into 32-bit words
	assign hi_one = src_one[cqr_pkg::XLEN-1:cqr_pkg::WLEN];
	assign lo_one = src_one[cqr_pkg::WLEN-1:0];
	assign hi_two = src_two[cqr_pkg::XLEN-1:cqr_pkg::WLEN];
	assign lo_two = src_two[cqr_pkg::WLEN-1:0];

	// First half: a, d from {a, d} and {b, c}
	always_comb begin
		ad_a1 = hi_one + hi_two;
		ad_d1 = cqr_pkg::rol32(lo_one ^ ad_a1, cqr_pkg::ROT_16);
		ad_c1 = lo_two + ad_d1;
		ad_b1 = cqr_pkg::rol32(hi_two ^ ad_c1, cqr_pkg::ROT_12);
		ad_a2 = ad_a1 + ad_b1;
		ad_d2 = cqr_pkg::rol32(ad_d1 ^ ad_a2, cqr_pkg::ROT_8);
	end

	// Second half: rebuild the intermediate d and c, then finish b and c
	always_comb begin
		bc_d1 = cqr_pkg::rol32(lo_one, cqr_pkg::ROT_24) ^ hi_one;
		bc_c1 = lo_two + bc_d1;
		bc_b1 = cqr_pkg::rol32(hi_two ^ bc_c1, cqr_pkg::ROT_12);
		bc_c2 = bc_c1 + lo_one;
		bc_b2 = cqr_pkg::rol32(bc_b1 ^ bc_c2, cqr_pkg::ROT_7);
	end

	assign ad_value = {ad_a2, ad_d2};
	assign bc_value = {bc_b2, bc_c2};

endmodule

`default_nettype wire

// ===== rtl/cqr_result_sel.sv =====
// ============================================================================
// cqr_result_sel: result selection
// Forms the pack variants and picks the destination value by opcode.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cqr_result_sel (
	input  wire [2:0]            cmd,
	input  wire cqr_pkg::xword_t src_one,
	input  wire cqr_pkg::xword_t src_two,
	input  wire cqr_pkg::xword_t ad_value,
	input  wire cqr_pkg::xword_t bc_value,
	output cqr_pkg::xword_t      dest_value
);

	// Decode the opcode; unused codes give zero
	always_comb begin
		unique case (cmd)
			cqr_pkg::CMD_PACK:
				dest_value = {src_two[cqr_pkg::WLEN-1:0], src_one[cqr_pkg::WLEN-1:0]};
			cqr_pkg::CMD_PACKH:
				dest_value = {src_two[cqr_pkg::XLEN-1:cqr_pkg::WLEN],
					src_one[cqr_pkg::XLEN-1:cqr_pkg::WLEN]};
			cqr_pkg::CMD_PACKHL:
				dest_value = {src_two[cqr_pkg::XLEN-1:cqr_pkg::WLEN],
					src_one[cqr_pkg::WLEN-1:0]};
			cqr_pkg::CMD_QR_AD: dest_value = ad_value;
			cqr_pkg::CMD_QR_BC: dest_value = bc_value;
			default:            dest_value = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/cqr_chk.sv =====
// ============================================================================
// cqr_chk: port-level checker for the quarter-round execute unit
// Watches command acceptance and result strobes over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cqr_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input wire [2:0]            cmd,
	input wire cqr_pkg::xword_t src_one,
	input wire cqr_pkg::xword_t src_two,
	input wire                  done,
	input wire cqr_pkg::xword_t dest_value
);

	// Every accepted transaction strobes a result after the input and result registers
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted transaction produced no result");

	// No result strobe without a transaction accepted through both registers before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		##2 (done |-> $past(start && !busy, 2)))
		else $error("result strobe without a transaction");

	// Unused opcodes give zero
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		##2 ((done && $past(cmd, 2) != cqr_pkg::CMD_PACK
			&& $past(cmd, 2) != cqr_pkg::CMD_PACKH
			&& $past(cmd, 2) != cqr_pkg::CMD_PACKHL
			&& $past(cmd, 2) != cqr_pkg::CMD_QR_AD
			&& $past(cmd, 2) != cqr_pkg::CMD_QR_BC) |-> dest_value == '0))
		else $error("unused opcode gave a nonzero result");

	// pack joins the low halves, rs2 over rs1
	a_pack_layout: assert property (@(posedge clk) disable iff (!arst_n)
		##2 ((done && $past(cmd, 2) == cqr_pkg::CMD_PACK) |->
			dest_value == {$past(src_two[31:0], 2), $past(src_one[31:0], 2)}))
		else $error("pack result has the wrong layout");

endmodule

bind chacha_quarter_round_alu cqr_chk u_cqr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.src_one    (src_one),
	.src_two    (src_two),
	.done       (done),
	.dest_value (dest_value)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top: testbench for the pack and quarter-round execute unit
// Drives commands through the start/busy handshake in random bursts and
// predicts each destination value. Results come back on the done strobe and
// are compared in order against the predicted values.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned STALL_LIMIT  = 500;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [2:0]      op;
		cqr_pkg::xword_t one;
		cqr_pkg::xword_t two;
		bit              drain_first;
	} instr_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [2:0]      cmd = '0;
	cqr_pkg::xword_t src_one = '0;
	cqr_pkg::xword_t src_two = '0;
	logic            busy;
	logic            done;
	cqr_pkg::xword_t dest_value;

	instr_t          pending[$];
	cqr_pkg::xword_t dest_due[$];
	int unsigned     fail_count = 0;
	int unsigned     idle_cycles = 0;
	int unsigned     burst_left = 1;
	int unsigned     gap_left = 0;

	chacha_quarter_round_alu dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.src_one    (src_one),
		.src_two    (src_two),
		.done       (done),
		.dest_value (dest_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Rotate a 32-bit word left by a fixed amount
	function automatic cqr_pkg::word_t word_rotl(input cqr_pkg::word_t x,
			input int unsigned k);
		logic [63:0] twice;
		twice = {x, x} << k;
		return twice[63:32];
	endfunction

	// Predict the destination value of one instruction
	function automatic cqr_pkg::xword_t execute_instr(input logic [2:0] op,
			input cqr_pkg::xword_t rs1, input cqr_pkg::xword_t rs2);
		cqr_pkg::word_t hi1, lo1, hi2, lo2;
		cqr_pkg::word_t a1, b1, c1, d1, a2, b2, c2, d2;
		hi1 = rs1[63:32];
		lo1 = rs1[31:0];
		hi2 = rs2[63:32];
		lo2 = rs2[31:0];
		case (op)
			cqr_pkg::CMD_PACK:   return {lo2, lo1};
			cqr_pkg::CMD_PACKH:  return {hi2, hi1};
			cqr_pkg::CMD_PACKHL: return {hi2, lo1};
			cqr_pkg::CMD_QR_AD: begin
				// rs1 = {a, d}, rs2 = {b, c}
				a1 = hi1 + hi2;
				d1 = word_rotl(lo1 ^ a1, cqr_pkg::ROT_16);
				c1 = lo2 + d1;
				b1 = word_rotl(hi2 ^ c1, cqr_pkg::ROT_12);
				a2 = a1 + b1;
				d2 = word_rotl(d1 ^ a2, cqr_pkg::ROT_8);
				return {a2, d2};
			end
			cqr_pkg::CMD_QR_BC: begin
				// rs1 = {new a, new d}, rs2 = {b, c}
				d1 = word_rotl(lo1, cqr_pkg::ROT_24) ^ hi1;
				c1 = lo2 + d1;
				b1 = word_rotl(hi2 ^ c1, cqr_pkg::ROT_12);
				c2 = c1 + lo1;
				b2 = word_rotl(b1 ^ c2, cqr_pkg::ROT_7);
				return {b2, c2};
			end
			default: return '0;
		endcase
	endfunction

	// Random source register, biased toward all-zero and all-one halves
	function automatic cqr_pkg::xword_t pick_src();
		cqr_pkg::word_t hi, lo;
		hi = $urandom;
		lo = $urandom;
		case ($urandom_range(0, 7))
			0: hi = '0;
			1: hi = '1;
			2: lo = '0;
			3: lo = '1;
			default: ;
		endcase
		return {hi, lo};
	endfunction

	task automatic push_instr(input logic [2:0] op, input cqr_pkg::xword_t s1,
			input cqr_pkg::xword_t s2, input bit drain);
		instr_t it;
		it.op = op;
		it.one = s1;
		it.two = s2;
		it.drain_first = drain;
		pending.push_back(it);
	endtask

	// Full quarter round: a/d half, then b/c half fed with its result
	task automatic push_round(input cqr_pkg::word_t a, input cqr_pkg::word_t b,
			input cqr_pkg::word_t c, input cqr_pkg::word_t d, input bit drain);
		cqr_pkg::xword_t ad;
		ad = execute_instr(cqr_pkg::CMD_QR_AD, {a, d}, {b, c});
		push_instr(cqr_pkg::CMD_QR_AD, {a, d}, {b, c}, drain);
		push_instr(cqr_pkg::CMD_QR_BC, ad, {b, c}, 1'b0);
	endtask

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fail_count++;
	endtask

	// Driver: retire the accepted transaction, then pace the next one
	always @(posedge clk) begin : drive_proc
		bit took;
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			go = 1'b0;
			if (took) begin
				dest_due.push_back(execute_instr(cmd, src_one, src_two));
				void'(pending.pop_front());
			end
			if (!start || took) begin
				if (pending.size() == 0) begin
					go = 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (pending[0].drain_first && dest_due.size() != 0) begin
					go = 1'b0;
				end else begin
					go = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				if (go) begin
					cmd <= pending[0].op;
					src_one <= pending[0].one;
					src_two <= pending[0].two;
				end
				start <= go;
			end
		end
	end

	// Monitor: check each strobed result against the oldest prediction
	always @(posedge clk) begin : check_proc
		cqr_pkg::xword_t want;
		if (arst_n && done) begin
			if (dest_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", dest_value));
			end else begin
				want = dest_due.pop_front();
				if (dest_value !== want)
					flag_mismatch($sformatf("dest_value %h, predicted %h", dest_value, want));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("Timeout after %0d idle cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stim_proc
		cqr_pkg::xword_t pat_one[3];
		cqr_pkg::xword_t pat_two[3];
		int unsigned n;
		bit mid_drain_done;
		pat_one = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA};
		pat_two = '{64'h0, '1, 64'h5555_5555_5555_5555};
		n = 0;
		mid_drain_done = 1'b0;

		// Directed: every opcode, reserved ones too, at extreme patterns
		for (int k = 0; k < 8; k++)
			for (int p = 0; p < 3; p++)
				push_instr(3'(k), pat_one[p], pat_two[p], 1'b0);
		// Fixed quarter-round vector, both halves chained
		push_round(32'h1111_1111, 32'h0102_0304, 32'h7777_7777, 32'h0123_4567, 1'b0);

		// Random: chained rounds mixed with single random opcodes
		while (n < RANDOM_ITEMS) begin
			bit drain;
			drain = (n == 0) || (!mid_drain_done && n >= RANDOM_ITEMS / 2);
			if (drain && n != 0)
				mid_drain_done = 1'b1;
			if ($urandom_range(0, 9) < 4) begin
				push_round($urandom, $urandom, $urandom, $urandom, drain);
				n += 2;
			end else begin
				push_instr(3'($urandom_range(0, 7)), pick_src(), pick_src(), drain);
				n++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all transactions to go through and all results to return
		do
			@(posedge clk);
		while (pending.size() != 0 || dest_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (dest_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", dest_due.size()));
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cqr_pkg.sv
rtl/cqr_qround.sv
rtl/cqr_result_sel.sv
rtl/chacha_quarter_round_alu.sv
rtl/cqr_chk.sv
sim/tb_top.sv
